// ----- sv/xxh64v_pkg.sv -----
// Package for the streaming xxhash64 variant core.
// Holds the hash primes, the multiplier request type and rotate helpers.
// No dependencies.
package xxh64v_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  localparam int unsigned STRIPE_BYTES = 32;
  localparam int unsigned LANES        = STRIPE_BYTES / 8;

  typedef struct packed {
    logic start;
    logic fold;
  } mul_req_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
    logic [6:0] rc;
    rc = 7'd64 - {1'b0, r};
    return (v << r) | (v >> rc);
  endfunction

  // Merge rotation for each lane.
  function automatic logic [5:0] merge_rot(input logic [1:0] k);
    logic [5:0] r;
    case (k)
      2'd0:    r = 6'd1;
      2'd1:    r = 6'd7;
      2'd2:    r = 6'd12;
      default: r = 6'd18;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/streaming_xxhash64_variant_core.sv -----
// Streaming xxhash64 variant: one message byte per request, one digest per message.
// A byte is taken only while the sequencer is idle; every 32nd byte starts the four
// lane updates on the shared four-phase 32x32 multiplier, and input stalls until done.
// Reset (rst_n, synchronous, active low) clears seed, counters and the result slot.
module streaming_xxhash64_variant_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,    // [7:0] byte_data
  input  logic          in_tlast,    // last_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,   // [63:0] digest_value, [127:64] message_length
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABS0  = 4'd1;
  localparam logic [3:0] S_ABS1  = 4'd2;
  localparam logic [3:0] S_ABS2  = 4'd3;
  localparam logic [3:0] S_MERGE = 4'd4;
  localparam logic [3:0] S_LEN   = 4'd5;
  localparam logic [3:0] S_TAIL  = 4'd6;
  localparam logic [3:0] S_TA    = 4'd7;
  localparam logic [3:0] S_TB    = 4'd8;
  localparam logic [3:0] S_AV1   = 4'd9;
  localparam logic [3:0] S_AV2   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // Tail step kinds.
  localparam logic [1:0] TK_W8 = 2'd0;
  localparam logic [1:0] TK_W4 = 2'd1;
  localparam logic [1:0] TK_B  = 2'd2;

  logic [3:0]  state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] acc_r [0:3];
  logic [63:0] acc_nxt [0:3];
  logic [7:0][7:0] lanes_r [0:3];   // stripe buffer, little-endian per lane
  logic [4:0]  fill_r, fill_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic        open_r, open_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [1:0]  tk_r, tk_nxt;
  logic [63:0] h_r, h_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_dig_r, out_dig_nxt, out_len_r, out_len_nxt;

  xxh64v_pkg::mul_req_t mul_req;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;

  logic [1:0]  rd_idx;
  logic [7:0][7:0] rd_word;
  logic        in_acc;
  logic [5:0]  len;
  logic [63:0] hx, t;
  logic [5:0]  tk_rot;
  logic [63:0] tk_k2;
  logic [5:0]  tk_step;

  xxh64v_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_idx    = (state_r == S_ABS0) ? k_r : pos_r[4:3];
  assign rd_word   = lanes_r[rd_idx];
  assign len       = {1'b0, fill_r};

  always_comb begin
    case (tk_r)
      TK_W8:   begin tk_rot = 6'd27; tk_k2 = xxh64v_pkg::P1; tk_step = 6'd8; end
      TK_W4:   begin tk_rot = 6'd23; tk_k2 = xxh64v_pkg::P2; tk_step = 6'd4; end
      default: begin tk_rot = 6'd11; tk_k2 = xxh64v_pkg::P1; tk_step = 6'd1; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    for (int i = 0; i < 4; i++) acc_nxt[i] = acc_r[i];
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    tk_nxt        = tk_r;
    h_nxt         = h_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dig_nxt   = out_dig_r;
    out_len_nxt   = out_len_r;
    mul_req.start = 1'b0;
    mul_req.fold  = 1'b0;
    mul_a         = 64'd0;
    mul_b         = 64'd0;
    hx            = h_r ^ mul_res;
    t             = 64'd0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Open a message: load the lanes from the seed as it stands now.
          if (!open_r) begin
            acc_nxt[0] = seed_r + xxh64v_pkg::P1 + xxh64v_pkg::P2;
            acc_nxt[1] = seed_r + xxh64v_pkg::P2;
            acc_nxt[2] = seed_r;
            acc_nxt[3] = seed_r - xxh64v_pkg::P1;
          end
          open_nxt = 1'b1;
          cnt_nxt  = cnt_r + 64'd1;
          fill_nxt = fill_r + 5'd1;    // wraps to zero on a full stripe
          last_nxt = in_tlast;
          k_nxt    = 2'd0;
          h_nxt    = 64'd0;
          if (fill_r == 5'd31) begin
            state_nxt = S_ABS0;
          end else if (in_tlast) begin
            state_nxt = S_MERGE;
          end
        end
      end
      S_ABS0: begin
        mul_req.start = 1'b1;
        mul_a         = rd_word;
        mul_b         = xxh64v_pkg::P2;
        state_nxt     = S_ABS1;
      end
      S_ABS1: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_a         = xxh64v_pkg::rotl(acc_r[k_r] + mul_res, 6'd31);
          mul_b         = xxh64v_pkg::P1;
          state_nxt     = S_ABS2;
        end
      end
      S_ABS2: begin
        if (mul_done) begin
          acc_nxt[k_r] = mul_res;
          k_nxt        = k_r + 2'd1;
          if (k_r != 2'd3) begin
            state_nxt = S_ABS0;
          end else if (last_r) begin
            state_nxt = S_MERGE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MERGE: begin
        // Long message: sum rotated lanes, one per cycle; short: seed start.
        if (cnt_r >= 64'(xxh64v_pkg::STRIPE_BYTES)) begin
          h_nxt = h_r + xxh64v_pkg::rotl(acc_r[k_r], xxh64v_pkg::merge_rot(k_r));
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) state_nxt = S_LEN;
        end else begin
          h_nxt     = seed_r + xxh64v_pkg::P5;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        h_nxt     = h_r + cnt_r;
        pos_nxt   = 6'd0;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        mul_req.start = 1'b1;
        state_nxt     = S_TA;
        if (pos_r + 6'd8 <= len) begin
          tk_nxt       = TK_W8;
          mul_req.fold = 1'b1;
          mul_a        = rd_word;
          mul_b        = xxh64v_pkg::P2;
        end else if (pos_r + 6'd4 <= len) begin
          tk_nxt = TK_W4;
          mul_a  = {32'd0, rd_word[3], rd_word[2], rd_word[1], rd_word[0]};
          mul_b  = xxh64v_pkg::P1;
        end else if (pos_r < len) begin
          tk_nxt = TK_B;
          mul_a  = {56'd0, rd_word[pos_r[2:0]]};
          mul_b  = xxh64v_pkg::P5;
        end else begin
          // Avalanche, first round.
          mul_a     = h_r ^ (h_r >> 33);
          mul_b     = xxh64v_pkg::P2;
          state_nxt = S_AV1;
        end
      end
      S_TA: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_a         = xxh64v_pkg::rotl(hx, tk_rot);
          mul_b         = tk_k2;
          state_nxt     = S_TB;
        end
      end
      S_TB: begin
        if (mul_done) begin
          h_nxt     = mul_res;
          pos_nxt   = pos_r + tk_step;
          state_nxt = S_TAIL;
        end
      end
      S_AV1: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_a         = mul_res ^ (mul_res >> 29);
          mul_b         = xxh64v_pkg::P3;
          state_nxt     = S_AV2;
        end
      end
      S_AV2: begin
        if (mul_done) begin
          t         = mul_res ^ (mul_res >> 32);
          h_nxt     = t;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the result slot is free, then close the message.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dig_nxt   = h_r;
          out_len_nxt   = cnt_r;
          open_nxt      = 1'b0;
          fill_nxt      = 5'd0;
          cnt_nxt       = 64'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 64'd0;
      fill_r      <= 5'd0;
      cnt_r       <= 64'd0;
      open_r      <= 1'b0;
      last_r      <= 1'b0;
      k_r         <= 2'd0;
      pos_r       <= 6'd0;
      tk_r        <= TK_W8;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) seed_r <= cfg_wdata;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      last_r      <= last_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      tk_r        <= tk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) acc_r[i] <= acc_nxt[i];
    h_r       <= h_nxt;
    out_dig_r <= out_dig_nxt;
    out_len_r <= out_len_nxt;
    if (in_acc) lanes_r[fill_r[4:3]][fill_r[2:0]] <= in_tdata;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_dig_r};

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_ABS1 || state_r == S_ABS2 || state_r == S_TA ||
                  state_r == S_TB || state_r == S_AV1 || state_r == S_AV2))
    else $error("multiplier result outside a wait state");
  a_busy_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> open_r)
    else $error("sequencer busy with no open message");
  a_fill_open: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != 5'd0) |-> open_r)
    else $error("buffered bytes with no open message");
  a_out_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE) |=> (out_tvalid && !open_r))
    else $error("result not posted on message close");
`endif

endmodule

// ----- sv/xxh64v_mul.sv -----
// Iterative 64x64 multiplier built on one 32x32 multiplier, four phases.
// Gives the low 64-bit product, or the split fold with the dropped carry.
// Depends on xxh64v_pkg.
module xxh64v_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xxh64v_pkg::mul_req_t  req,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  output logic                  done,
  output logic [63:0]           res
);

  logic [63:0] a_r, b_r, lo_r, cross_r, res_r;
  logic        fold_r, busy_r, done_r;
  logic [1:0]  ph_r;
  logic [31:0] x, y;
  logic [63:0] prod, hi, low;

  always_comb begin
    case (ph_r)
      2'd0:    begin x = a_r[31:0];  y = b_r[31:0];  end
      2'd1:    begin x = a_r[63:32]; y = b_r[31:0];  end
      2'd2:    begin x = a_r[31:0];  y = b_r[63:32]; end
      default: begin x = a_r[63:32]; y = b_r[63:32]; end
    endcase
    prod = {32'd0, x} * {32'd0, y};
    hi   = prod + {32'd0, cross_r[63:32]};
    low  = lo_r + {cross_r[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= a;
        b_r    <= b;
        fold_r <= req.fold;
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        case (ph_r)
          2'd0:    lo_r    <= prod;
          2'd1:    cross_r <= prod;
          2'd2:    cross_r <= cross_r + prod;
          default: begin
            res_r  <= fold_r ? (hi ^ low) : low;
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
